FILE: src/assert_macros.svh
// assertion macros shared by the route selector rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is high
`define RBPS_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked on every edge
`define RBPS_ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/rbps_pkg.sv
// types and constants for the route best path selector
package rbps_pkg;

   localparam int MaxCandidatesDefault = 256;
   localparam int CountWidth = 9;
   localparam int CountLimit = 511;

   // deciding step codes at the ends of the range
   localparam logic [2:0] STEP_ONLY_PATH = 3'd0;
   localparam logic [2:0] STEP_PEER_IP = 3'd6;

   localparam logic [7:0] POSITION_MAX = 8'hFF;

   typedef struct packed {
      logic [31:0] pref;
      logic [7:0]  path_len;
      logic [1:0]  origin;
      logic [31:0] med;
      logic [31:0] router;
      logic [31:0] peer;
   } route_keys_type;

   typedef struct packed {
      logic       wins;
      logic [2:0] shared;
   } cmp_result_type;

endpackage

FILE: src/rbps_cmp.sv
// six-key lexicographic compare of a candidate against the current best
module rbps_cmp
   import rbps_pkg::*;
(
   input  route_keys_type cand,
   input  route_keys_type best,
   output cmp_result_type result
);

   // first differing key decides, local preference is higher-better
   always_comb begin
      result = '{wins: 1'b0, shared: 3'd6};
      priority if (cand.pref != best.pref) begin
         result = '{wins: cand.pref > best.pref, shared: 3'd0};
      end else if (cand.path_len != best.path_len) begin
         result = '{wins: cand.path_len < best.path_len, shared: 3'd1};
      end else if (cand.origin != best.origin) begin
         result = '{wins: cand.origin < best.origin, shared: 3'd2};
      end else if (cand.med != best.med) begin
         result = '{wins: cand.med < best.med, shared: 3'd3};
      end else if (cand.router != best.router) begin
         result = '{wins: cand.router < best.router, shared: 3'd4};
      end else if (cand.peer != best.peer) begin
         result = '{wins: cand.peer < best.peer, shared: 3'd5};
      end else begin
         result = '{wins: 1'b0, shared: 3'd6};
      end
   end

endmodule

FILE: src/rbps_group.sv
// per-group winner state and result fields for the route selector
module rbps_group
   import rbps_pkg::*;
#(
   parameter int MAX_CANDIDATES = MaxCandidatesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic                  last,
   input  route_keys_type        cand,
   output logic [7:0]            best_position,
   output logic [2:0]            deciding_step,
   output logic [CountWidth-1:0] group_count
);

   localparam int CountCapInt =
      (MAX_CANDIDATES < CountLimit) ? MAX_CANDIDATES : CountLimit;
   localparam logic [CountWidth-1:0] CountCap = CountWidth'(CountCapInt);

   route_keys_type        best_ff;
   logic [7:0]            best_pos_ff;
   logic [CountWidth-1:0] seen_ff;
   logic [2:0]            max_shared_ff;

   route_keys_type        best_in;
   logic [7:0]            best_pos_in;
   logic [CountWidth-1:0] seen_in;
   logic [2:0]            max_shared_in;

   cmp_result_type        cmp;
   logic                  empty;
   logic                  take;
   logic [7:0]            pos;
   logic [3:0]            step_sum;

   rbps_cmp u_cmp (
      .cand   (cand),
      .best   (best_ff),
      .result (cmp)
   );

   // candidate position, held at the top once the group runs long
   assign empty = (seen_ff == '0);
   assign take  = empty || cmp.wins;
   assign pos   = (seen_ff > CountWidth'(POSITION_MAX)) ? POSITION_MAX : seen_ff[7:0];

   // updated group state for this beat
   always_comb begin
      best_in     = take ? cand : best_ff;
      best_pos_in = take ? pos : best_pos_ff;
      if (empty) begin
         max_shared_in = 3'd0;
      end else if (cmp.wins) begin
         max_shared_in = cmp.shared;
      end else if (cmp.shared > max_shared_ff) begin
         max_shared_in = cmp.shared;
      end else begin
         max_shared_in = max_shared_ff;
      end
      seen_in = (seen_ff < CountCap) ? seen_ff + CountWidth'(1) : seen_ff;
   end

   // result fields, valid on the closing beat of a group
   always_comb begin
      step_sum = {1'b0, max_shared_in} + 4'd1;
      if (seen_in <= CountWidth'(1)) begin
         deciding_step = STEP_ONLY_PATH;
      end else if (step_sum > {1'b0, STEP_PEER_IP}) begin
         deciding_step = STEP_PEER_IP;
      end else begin
         deciding_step = step_sum[2:0];
      end
      best_position = best_pos_in;
      group_count   = seen_in;
   end

   // control state, cleared at group end
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= '0;
         max_shared_ff <= 3'd0;
      end else if (fire) begin
         if (last) begin
            seen_ff       <= '0;
            max_shared_ff <= 3'd0;
         end else begin
            seen_ff       <= seen_in;
            max_shared_ff <= max_shared_in;
         end
      end
   end

   // winner keys, reloaded by the first beat of each group
   always_ff @(posedge clock) begin
      if (fire) begin
         best_ff     <= best_in;
         best_pos_ff <= best_pos_in;
      end
   end

endmodule

FILE: src/route_best_path_select.sv
// top level of the streaming route best path selector
//
//   channel | prefix | carries
//   --------+--------+-----------------------------------------------
//   input   | req_   | one candidate route per beat, last flag
//   result  | rsp_   | winner position, deciding step, group count
//
// one candidate per clock unless a closing beat stalls; each beat passes
// through the input register and folds into the group state as it leaves
// it, and the closing beat's result is then held in the output register.
// reset clears the valid flags and the group count; no clearing pass.
// a result waiting in the output register stalls only a closing beat;
// other beats keep flowing past it.
module route_best_path_select
   import rbps_pkg::*;
#(
   parameter int MAX_CANDIDATES = MaxCandidatesDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_local_pref,
   input  logic [7:0]            req_as_path_len,
   input  logic [1:0]            req_origin_code,
   input  logic [31:0]           req_med,
   input  logic [31:0]           req_router_id,
   input  logic [31:0]           req_peer_ip,
   input  logic                  req_last_in_group,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_best_position,
   output logic [2:0]            rsp_deciding_step,
   output logic [CountWidth-1:0] rsp_group_count
);

`include "assert_macros.svh"

   logic                  in_valid_ff;
   route_keys_type        in_keys_ff;
   logic                  in_last_ff;

   logic                  out_valid_ff;
   logic [7:0]            out_pos_ff;
   logic [2:0]            out_step_ff;
   logic [CountWidth-1:0] out_count_ff;

   logic                  fire;
   logic [7:0]            grp_pos;
   logic [2:0]            grp_step;
   logic [CountWidth-1:0] grp_count;

   // stage advances unless a closing beat meets a full output register
   assign fire      = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;

   // input register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_keys_ff <= '{pref:     req_local_pref,
                         path_len: req_as_path_len,
                         origin:   req_origin_code,
                         med:      req_med,
                         router:   req_router_id,
                         peer:     req_peer_ip};
         in_last_ff <= req_last_in_group;
      end
   end

   rbps_group #(
      .MAX_CANDIDATES (MAX_CANDIDATES)
   ) u_group (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .last          (in_last_ff),
      .cand          (in_keys_ff),
      .best_position (grp_pos),
      .deciding_step (grp_step),
      .group_count   (grp_count)
   );

   // output register valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (fire && in_last_ff) begin
         out_pos_ff   <= grp_pos;
         out_step_ff  <= grp_step;
         out_count_ff <= grp_count;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_best_position = out_pos_ff;
   assign rsp_deciding_step = out_step_ff;
   assign rsp_group_count   = out_count_ff;

   // result checks
   `RBPS_ASSERT_RST(a_step_range, clock, reset, rsp_valid |-> rsp_deciding_step <= STEP_PEER_IP, "deciding step out of range")
   `RBPS_ASSERT_RST(a_count_nonzero, clock, reset, rsp_valid |-> rsp_group_count != '0, "empty group reported")
   `RBPS_ASSERT_RST(a_single_step, clock, reset, rsp_valid |-> ((rsp_group_count <= CountWidth'(1)) == (rsp_deciding_step == STEP_ONLY_PATH)), "step zero does not match a single path")
   `RBPS_ASSERT_RST(a_pos_in_group, clock, reset, rsp_valid |-> CountWidth'(rsp_best_position) < rsp_group_count, "winner position outside group")
   `RBPS_ASSERT_CLK(a_stall_on_full, clock, (!reset && in_valid_ff && in_last_ff && out_valid_ff && !rsp_ready) |-> !req_ready, "closing beat passed a full output")

endmodule

FILE: tb/sv/route_best_path_select_test.sv
// self-checking testbench for the streaming route best path selector
`timescale 1ns / 1ps

module route_best_path_select_test;
   import rbps_pkg::*;

   localparam int MaxCandidates = MaxCandidatesDefault;
   localparam int CountCap = (MaxCandidates < CountLimit) ? MaxCandidates : CountLimit;
   localparam int WatchdogLimit = 500;
   localparam int DrainCycles = 10;

   // key order of the selection, most significant first
   typedef enum int {
      KEY_PREF = 0,
      KEY_PATH,
      KEY_ORIGIN,
      KEY_MED,
      KEY_ROUTER,
      KEY_PEER,
      NUM_KEYS
   } key_index_type;

   typedef logic [NUM_KEYS-1:0][31:0] cand_keys_type;

   typedef struct {
      logic [7:0]            pos;
      logic [2:0]            step;
      logic [CountWidth-1:0] count;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [31:0]           req_local_pref;
   logic [7:0]            req_as_path_len;
   logic [1:0]            req_origin_code;
   logic [31:0]           req_med;
   logic [31:0]           req_router_id;
   logic [31:0]           req_peer_ip;
   logic                  req_last_in_group;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_best_position;
   logic [2:0]            rsp_deciding_step;
   logic [CountWidth-1:0] rsp_group_count;

   // selector state mirrored by the testbench
   cand_keys_type sel_best;
   int            sel_pos;
   int            sel_seen;
   int            sel_shared;

   verdict_type   expected_verdicts[$];
   int            mismatches = 0;
   int            idle_cycles = 0;
   bit            steady_flow = 1'b0;

   route_best_path_select #(
      .MAX_CANDIDATES(MaxCandidates)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_local_pref(req_local_pref),
      .req_as_path_len(req_as_path_len),
      .req_origin_code(req_origin_code),
      .req_med(req_med),
      .req_router_id(req_router_id),
      .req_peer_ip(req_peer_ip),
      .req_last_in_group(req_last_in_group),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_best_position(rsp_best_position),
      .rsp_deciding_step(rsp_deciding_step),
      .rsp_group_count(rsp_group_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // width of each key field
   function automatic int key_width(int idx);
      unique case (idx)
         KEY_PATH:   return 8;
         KEY_ORIGIN: return 2;
         default:    return 32;
      endcase
   endfunction

   function automatic logic [31:0] key_mask(int idx);
      return (32'd1 << key_width(idx)) - 32'd1;
   endfunction

   // field value biased towards the ends of its range
   function automatic logic [31:0] pick_value(int idx);
      unique case ($urandom_range(0, 9))
         0, 1:    return 32'd0;
         2, 3:    return key_mask(idx);
         4:       return 32'd1;
         default: return $urandom & key_mask(idx);
      endcase
   endfunction

   function automatic cand_keys_type random_keys();
      cand_keys_type k;
      for (int i = 0; i < NUM_KEYS; i++) k[i] = pick_value(i);
      return k;
   endfunction

   // candidate that agrees with base on the first n keys and differs on the next
   function automatic cand_keys_type near_keys(cand_keys_type base, int n);
      cand_keys_type k;
      k = random_keys();
      for (int i = 0; i < n; i++) k[i] = base[i];
      if (n < NUM_KEYS && k[n] == base[n]) k[n] = (base[n] ^ 32'd1) & key_mask(n);
      return k;
   endfunction

   function automatic cand_keys_type make_keys(logic [31:0] pref, logic [7:0] path,
                                               logic [1:0] origin, logic [31:0] med,
                                               logic [31:0] router, logic [31:0] peer);
      cand_keys_type k;
      k[KEY_PREF]   = pref;
      k[KEY_PATH]   = {24'd0, path};
      k[KEY_ORIGIN] = {30'd0, origin};
      k[KEY_MED]    = med;
      k[KEY_ROUTER] = router;
      k[KEY_PEER]   = peer;
      return k;
   endfunction

   // number of leading keys on which two candidates agree
   function automatic int shared_keys(cand_keys_type a, cand_keys_type b);
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (a[i] != b[i]) return i;
      end
      return NUM_KEYS;
   endfunction

   // fold one accepted candidate into the group, queue a verdict on the last
   task automatic track_candidate(cand_keys_type cand, logic last);
      int          shared;
      int          pos;
      int          step;
      bit          wins;
      verdict_type v;
      pos = (sel_seen > 255) ? 255 : sel_seen;
      if (sel_seen == 0) begin
         sel_best   = cand;
         sel_pos    = pos;
         sel_shared = 0;
      end else begin
         shared = shared_keys(cand, sel_best);
         wins = 1'b0;
         if (shared < NUM_KEYS) begin
            if (shared == KEY_PREF) wins = cand[shared] > sel_best[shared];
            else wins = cand[shared] < sel_best[shared];
         end
         if (wins) begin
            sel_best   = cand;
            sel_pos    = pos;
            sel_shared = shared;
         end else if (shared > sel_shared) begin
            sel_shared = shared;
         end
      end
      if (sel_seen < CountCap) sel_seen++;
      if (last) begin
         if (sel_seen <= 1) step = STEP_ONLY_PATH;
         else if (sel_shared + 1 > STEP_PEER_IP) step = STEP_PEER_IP;
         else step = sel_shared + 1;
         v.pos   = sel_pos[7:0];
         v.step  = step[2:0];
         v.count = sel_seen[CountWidth-1:0];
         expected_verdicts = {expected_verdicts, v};
         sel_best   = '0;
         sel_pos    = 0;
         sel_seen   = 0;
         sel_shared = 0;
      end
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // send one candidate beat, with an occasional gap ahead of it
   task automatic send_route(cand_keys_type k, logic last);
      @(negedge clock);
      if (!steady_flow && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_local_pref    <= k[KEY_PREF];
      req_as_path_len   <= k[KEY_PATH][7:0];
      req_origin_code   <= k[KEY_ORIGIN][1:0];
      req_med           <= k[KEY_MED];
      req_router_id     <= k[KEY_ROUTER];
      req_peer_ip       <= k[KEY_PEER];
      req_last_in_group <= last;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_candidate(k, last);
   endtask

   // one-candidate groups at both extremes
   task automatic test_single_paths();
      send_route(make_keys(32'd0, 8'd0, 2'd0, 32'd0, 32'd0, 32'd0), 1'b1);
      send_route(make_keys('1, '1, 2'd3, '1, '1, '1), 1'b1);
   endtask

   // two-candidate groups that split at each key in turn, won and lost
   task automatic test_each_deciding_step();
      cand_keys_type base;
      cand_keys_type other;
      base = make_keys(32'h8000_0000, 8'd100, 2'd1, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000);
      for (int k = 0; k < NUM_KEYS; k++) begin
         other = base;
         if (k % 2 == 0) other[k] = (k == KEY_PREF) ? key_mask(k) : 32'd0;
         else other[k] = key_mask(k);
         send_route(base, 1'b0);
         send_route(other, 1'b1);
      end
   endtask

   // identical candidates: the earlier one is kept
   task automatic test_exact_tie();
      cand_keys_type k;
      k = make_keys(32'd7, 8'd3, 2'd2, 32'd9, 32'd11, 32'd13);
      send_route(k, 1'b0);
      send_route(k, 1'b1);
   endtask

   // origin code three is just a larger number and loses
   task automatic test_origin_three();
      send_route(make_keys(32'd5, 8'd2, 2'd3, 32'd0, 32'd0, 32'd0), 1'b0);
      send_route(make_keys(32'd5, 8'd2, 2'd0, '1, '1, '1), 1'b1);
   endtask

   // a loser after the winner agrees with it further than the displaced one
   task automatic test_shared_prefix();
      send_route(make_keys(32'd5, 8'd4, 2'd1, 32'd10, 32'd1, 32'd1), 1'b0);
      send_route(make_keys(32'd5, 8'd3, 2'd1, 32'd10, 32'd1, 32'd1), 1'b0);
      send_route(make_keys(32'd5, 8'd3, 2'd1, 32'd20, 32'd0, 32'd0), 1'b1);
   endtask

   // long group past the count limit, winner late, tie after it if the group runs on
   task automatic test_late_winner(int length, int win_at);
      cand_keys_type k;
      cand_keys_type champ;
      champ = make_keys('1, 8'd0, 2'd0, 32'd0, 32'd0, 32'd0);
      for (int j = 0; j < length; j++) begin
         if (j == win_at || j == win_at + 5) begin
            k = champ;
         end else begin
            k = random_keys();
            k[KEY_PREF] = $urandom_range(0, 1000);
         end
         send_route(k, j == length - 1);
      end
   endtask

   // random groups whose members agree on a random number of leading keys
   task automatic test_random_groups(int item_goal);
      int            sent;
      int            mode;
      int            size;
      cand_keys_type base;
      cand_keys_type cand;
      sent = 0;
      while (sent < item_goal) begin
         mode = $urandom_range(0, 99);
         if (mode < 5) size = 1;
         else if (mode < 75) size = $urandom_range(2, 6);
         else size = $urandom_range(7, 20);
         base = random_keys();
         for (int j = 0; j < size; j++) begin
            if ($urandom_range(0, 9) == 0) cand = random_keys();
            else cand = near_keys(base, $urandom_range(0, NUM_KEYS));
            send_route(cand, j == size - 1);
            if ($urandom_range(0, 3) == 0) base = cand;
            sent++;
         end
      end
   endtask

   // burst with neither side idling
   task automatic test_steady_burst(int item_goal);
      steady_flow = 1'b1;
      test_random_groups(item_goal);
      steady_flow = 1'b0;
   endtask

   // result side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= steady_flow || ($urandom_range(0, 99) >= 8);
      end
   end

   // compare each result beat with the oldest verdict
   always @(posedge clock) begin : check_results
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_verdicts.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_group_count, 0);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_best_position !== want.pos)
               report_mismatch("best_position", rsp_best_position, want.pos);
            if (rsp_deciding_step !== want.step)
               report_mismatch("deciding_step", rsp_deciding_step, want.step);
            if (rsp_group_count !== want.count)
               report_mismatch("group_count", rsp_group_count, want.count);
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // stimulus sequence
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_local_pref    = '0;
      req_as_path_len   = '0;
      req_origin_code   = '0;
      req_med           = '0;
      req_router_id     = '0;
      req_peer_ip       = '0;
      req_last_in_group = 1'b0;
      sel_best          = '0;
      sel_pos           = 0;
      sel_seen          = 0;
      sel_shared        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_single_paths();
      test_each_deciding_step();
      test_exact_tie();
      test_origin_three();
      test_shared_prefix();
      test_late_winner(300, 280);
      test_late_winner(257, 255);
      test_steady_burst(250);
      test_random_groups(600);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (mismatches == 0 && expected_verdicts.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

FILE: route_best_path_select.f
+incdir+src
src/rbps_pkg.sv
src/rbps_cmp.sv
src/rbps_group.sv
src/route_best_path_select.sv
tb/sv/route_best_path_select_test.sv
